>>> rtl/zpd_pkg.sv
// ----------------------------------------------------------------------------
// zpd_pkg
// Shared constants, types and helpers for the zone pixel density block.
// ----------------------------------------------------------------------------
package zpd_pkg;

   // Zone grid and image size limits
   localparam int ZONE_ROWS = 4;
   localparam int ZONE_COLS = 4;
   localparam int MAX_DIM   = 256;

   // Position counters hold 0 .. MAX_DIM-1, dimensions hold 1 .. MAX_DIM
   localparam int POS_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = POS_W + 1;
   localparam int AREA_W = 2 * POS_W + 1;

   // Fixed widths of the register file and of the result fields
   localparam int CFG_DIM_W  = 9;
   localparam int CFG_SEL_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int CNT_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int STEP_W     = $clog2(FRAC_W);

   // Width used to compare or divide set count against zone area
   localparam int CMP_W = (AREA_W > CNT_W) ? AREA_W : CNT_W;

   // Q1.16 full scale; also the saturation point of the set count
   localparam logic [CNT_W-1:0] FULL_SCALE = CNT_W'(65536);

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_ROW     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_COL     = 2'd3;

   // Reset values of the registers
   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd64;
   localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd64;
   localparam logic [CFG_SEL_W-1:0] RST_ZONE_SEL     = 2'd0;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_height;
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_SEL_W-1:0] zone_row;
      logic [CFG_SEL_W-1:0] zone_col;
   } cfg_type;

   // One finished frame handed from the front to the back
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [DIM_W-1:0] zone_h;
      logic [DIM_W-1:0] zone_w;
   } job_type;

   // Zero counts as one, anything above MAX_DIM counts as MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // Saturate a zone selector to the last zone
   function automatic logic [DIM_W-1:0] clamp_sel(input logic [CFG_SEL_W-1:0] v,
                                                  input int zones);
      logic [DIM_W-1:0] r;
      if (int'(v) >= zones) begin
         r = DIM_W'(zones - 1);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/zpd_front.sv
// ----------------------------------------------------------------------------
// zpd_front
// Pixel front end: tracks the raster position, counts set pixels inside the
// selected zone and hands one job per frame to the queue.
// ----------------------------------------------------------------------------
module zpd_front (
   input  logic             clock,
   input  logic             reset,
   input  zpd_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_pixel,
   input  logic             q_full,
   output logic             push,
   output zpd_pkg::job_type push_job
);
   import zpd_pkg::*;

   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic [CNT_W-1:0] ones_ff, ones_in;

   logic [DIM_W-1:0] dim_h, dim_w;
   logic [DIM_W-1:0] sel_r, sel_c;
   logic [DIM_W-1:0] size_h, size_w;
   logic [DIM_W-1:0] ys, ye, xs, xe;
   logic [DIM_W-1:0] row_ext, col_ext;
   logic             in_zone, hit;
   logic [CNT_W-1:0] ones_sum;
   logic             row_done, frame_done, accept;

   // Zone bounds from the live registers
   always_comb begin
      dim_h  = clamp_dim(cfg.image_height);
      dim_w  = clamp_dim(cfg.image_width);
      sel_r  = clamp_sel(cfg.zone_row, ZONE_ROWS);
      sel_c  = clamp_sel(cfg.zone_col, ZONE_COLS);
      size_h = dim_h / DIM_W'(ZONE_ROWS);
      size_w = dim_w / DIM_W'(ZONE_COLS);
      ys     = sel_r * size_h;
      xs     = sel_c * size_w;
      ye     = (sel_r == DIM_W'(ZONE_ROWS - 1)) ? dim_h : (sel_r + DIM_W'(1)) * size_h;
      xe     = (sel_c == DIM_W'(ZONE_COLS - 1)) ? dim_w : (sel_c + DIM_W'(1)) * size_w;
   end

   // Classify the pixel and count it, saturating at full scale
   always_comb begin
      row_ext    = {1'b0, row_pos_ff};
      col_ext    = {1'b0, col_pos_ff};
      in_zone    = (row_ext >= ys) && (row_ext < ye) && (col_ext >= xs) && (col_ext < xe);
      hit        = req_pixel && in_zone;
      ones_sum   = (hit && (ones_ff < FULL_SCALE)) ? ones_ff + CNT_W'(1) : ones_ff;
      row_done   = col_ext >= (dim_w - DIM_W'(1));
      frame_done = row_done && (row_ext >= (dim_h - DIM_W'(1)));
   end

   // Hold the channel while the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Hand the finished frame to the back
   assign push            = accept && frame_done;
   assign push_job.count  = ones_sum;
   assign push_job.zone_h = ye - ys;
   assign push_job.zone_w = xe - xs;

   // Advance the raster position
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      ones_in    = ones_ff;
      if (accept) begin
         if (frame_done) begin
            col_pos_in = '0;
            row_pos_in = '0;
            ones_in    = '0;
         end else if (row_done) begin
            col_pos_in = '0;
            row_pos_in = row_pos_ff + POS_W'(1);
            ones_in    = ones_sum;
         end else begin
            col_pos_in = col_pos_ff + POS_W'(1);
            ones_in    = ones_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         ones_ff    <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         ones_ff    <= ones_in;
      end
   end

endmodule

>>> rtl/zpd_queue.sv
// ----------------------------------------------------------------------------
// zpd_queue
// Short job queue between the pixel front end and the density back end.
// ----------------------------------------------------------------------------
module zpd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  zpd_pkg::job_type push_job,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output zpd_pkg::job_type pop_job
);
   import zpd_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   level_ff, level_in;
   logic              do_push, do_pop;

   assign full      = (level_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (level_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && pop_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/zpd_back.sv
// ----------------------------------------------------------------------------
// zpd_back
// Density back end: zone area multiply, one quotient bit per cycle
// restoring division and the result register.
// ----------------------------------------------------------------------------
module zpd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop,
   input  zpd_pkg::job_type          pop_job,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [zpd_pkg::CNT_W-1:0] rsp_density,
   output logic [zpd_pkg::CNT_W-1:0] rsp_set_count,
   output logic                      rsp_zone_empty
);
   import zpd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_AREA  = 5'b00010,
      S_CHECK = 5'b00100,
      S_DIV   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [CMP_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  dens_ff, dens_in;
   logic [CNT_W-1:0]  setc_ff, setc_in;
   logic              empty_ff, empty_in;

   logic [CMP_W-1:0]  count_ext, area_ext;
   logic [CMP_W:0]    rem_dbl, area_dbl;
   logic              fits;

   always_comb begin
      count_ext = CMP_W'(job_ff.count);
      area_ext  = CMP_W'(area_ff);
      rem_dbl   = {rem_ff, 1'b0};
      area_dbl  = {1'b0, area_ext};
      fits      = rem_dbl >= area_dbl;
   end

   assign pop            = (state_ff == S_IDLE) && pop_valid;
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_density    = dens_ff;
   assign rsp_set_count  = setc_ff;
   assign rsp_zone_empty = empty_ff;

   // Sequence one job through area, check, divide and result
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      area_in  = area_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      dens_in  = dens_ff;
      setc_in  = setc_ff;
      empty_in = empty_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_job;
               state_in = S_AREA;
            end
         end
         S_AREA: begin
            area_in  = AREA_W'(job_ff.zone_h) * AREA_W'(job_ff.zone_w);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Empty zone and full saturation skip the divide
            rem_in  = count_ext;
            step_in = '0;
            dens_in = '0;
            if (area_ff == '0) begin
               setc_in  = '0;
               empty_in = 1'b1;
               state_in = S_OUT;
            end else if (count_ext >= area_ext) begin
               dens_in  = FULL_SCALE;
               setc_in  = job_ff.count;
               empty_in = 1'b0;
               state_in = S_OUT;
            end else begin
               setc_in  = job_ff.count;
               empty_in = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = fits ? CMP_W'(rem_dbl - area_dbl) : CMP_W'(rem_dbl);
            dens_in = {dens_ff[CNT_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      area_ff  <= area_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      dens_ff  <= dens_in;
      setc_ff  <= setc_in;
      empty_ff <= empty_in;
   end

endmodule

>>> rtl/zone_pixel_density.sv
// ----------------------------------------------------------------------------
// zone_pixel_density
// Counts set pixels of a binary raster frame inside one selected zone of a
// ZONE_ROWS by ZONE_COLS grid and reports the zone density in Q1.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one pixel per beat in raster order; the block takes
//   one beat per cycle while its job queue has room.
//   rsp_ channel carries one beat per frame: density, set_count, zone_empty.
//   csr_ port writes image_height, image_width, zone_row, zone_col by index;
//   write only while no frame is in progress or still being reported.
// Result path: after its last pixel beat, a frame passes the queue hand-off,
//   area multiply, check and the one bit per cycle divider. Zero-area and
//   saturated zones skip the divider.
// Throughput: one pixel per cycle while the queue has room; frames that come
//   faster than the back end finishes them fill the two-entry queue and
//   req_stall rises until the back end pops a job and frees a slot.
// Reset: registers return to 64 x 64, zone 0/0; position and count clear.
// Receiver stall: the result beat holds in the output register; the front
//   keeps taking pixels until the queue fills.
// ----------------------------------------------------------------------------
module zone_pixel_density (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [zpd_pkg::CNT_W-1:0]      rsp_density,
   output logic [zpd_pkg::CNT_W-1:0]      rsp_set_count,
   output logic                           rsp_zone_empty,
   input  logic                           csr_wr_en,
   input  logic [zpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [zpd_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import zpd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full, push, pop, pop_valid;
   job_type push_job, pop_job;

   // Register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wr_data[CFG_DIM_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wr_data[CFG_DIM_W-1:0];
            CSR_ZONE_ROW:     cfg_in.zone_row     = csr_wr_data[CFG_SEL_W-1:0];
            CSR_ZONE_COL:     cfg_in.zone_col     = csr_wr_data[CFG_SEL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_height <= RST_IMAGE_HEIGHT;
         cfg_ff.image_width  <= RST_IMAGE_WIDTH;
         cfg_ff.zone_row     <= RST_ZONE_SEL;
         cfg_ff.zone_col     <= RST_ZONE_SEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   zpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   zpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job)
   );

   zpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop            (pop),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_density    (rsp_density),
      .rsp_set_count  (rsp_set_count),
      .rsp_zone_empty (rsp_zone_empty)
   );

   // A finished frame never meets a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("frame job pushed into a full queue");

   // An empty zone reports zero density and zero count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zone_empty) |-> (rsp_density == '0 && rsp_set_count == '0))
      else $error("empty zone reported nonzero result");

   // Density never exceeds full scale
   a_dens_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_density <= FULL_SCALE))
      else $error("density above full scale");

   // A result beat that is taken is not repeated: the back end returns to idle
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result beat repeated");

endmodule
